// File: sv/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, off while reset is held.
`define TVDS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define TVDS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

// File: sv/tvds_pkg.sv
// Types, codes and constants of the timed valve dispense sequencer.
`default_nettype none

package tvds_pkg;

  // Elapsed millisecond counter width.
  localparam int TIME_WIDTH = 32;
  // Fraction bits of a Q12 time value.
  localparam int FRAC_W     = 12;
  // Time compare width: elapsed in Q12, or the largest threshold sum.
  localparam int CMP_W      = (TIME_WIDTH + FRAC_W > 35) ? TIME_WIDTH + FRAC_W : 35;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MILK_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_DELAY = 3'd5;

  // Register reset values.
  localparam logic [15:0] RST_RATE        = 16'd256;
  localparam logic [15:0] RST_MAX_LEVEL   = 16'hFFFF;
  localparam logic [15:0] RST_TRAVEL      = 16'd1000;
  localparam logic [15:0] RST_DRAIN_DELAY = 16'd0;

  // Fluid codes.
  localparam logic [1:0] FL_NONE  = 2'd0;
  localparam logic [1:0] FL_DRAIN = 2'd1;
  localparam logic [1:0] FL_WATER = 2'd2;
  localparam logic [1:0] FL_MILK  = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_TICK   = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_UNDEF  = 3'd2;
  localparam logic [2:0] ST_OVFL   = 3'd3;
  localparam logic [2:0] ST_BUSY   = 3'd4;

  // Relay mask bits.
  localparam logic [3:0] R_DRAIN = 4'b0001;
  localparam logic [3:0] R_WATER = 4'b0010;
  localparam logic [3:0] R_MILK  = 4'b0100;
  localparam logic [3:0] R_AIR   = 4'b1000;

  typedef struct packed {
    logic [15:0] drain_ms_per_ml;
    logic [15:0] water_ms_per_ml;
    logic [15:0] milk_ms_per_ml;
    logic [15:0] max_bowl_level;
    logic [15:0] travel_time_ms;
    logic [15:0] drain_delay_ms;
  } tvds_cfg_t;

  typedef struct packed {
    logic        action;
    logic [1:0]  fluid_type;
    logic [15:0] volume;
    logic        drain_after;
  } tvds_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        drain_valve;
    logic        water_valve;
    logic        milk_valve;
    logic        air_valve;
    logic        busy_res;
    logic        finished;
    logic [15:0] bowl_level;
  } tvds_res_t;

  // Valve time per ml for a fluid; undefined fluid has zero open time.
  function automatic logic [15:0] rate_of(tvds_cfg_t cfg, logic [1:0] fluid);
    logic [15:0] r;
    case (fluid)
      FL_DRAIN: r = cfg.drain_ms_per_ml;
      FL_WATER: r = cfg.water_ms_per_ml;
      FL_MILK:  r = cfg.milk_ms_per_ml;
      default:  r = 16'd0;
    endcase
    return r;
  endfunction

  // Source relay of a fluid; undefined fluid drives the air relay.
  function automatic logic [3:0] relay_of(logic [1:0] fluid);
    logic [3:0] m;
    case (fluid)
      FL_DRAIN: m = R_DRAIN;
      FL_WATER: m = R_WATER;
      FL_MILK:  m = R_MILK;
      default:  m = R_AIR;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: sv/tvds_core.sv
// Sequencer state and the one-step update for a tick or a request beat.
`default_nettype none

module tvds_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire tvds_pkg::tvds_item_t item,
  input  wire tvds_pkg::tvds_cfg_t  cfg,
  output tvds_pkg::tvds_res_t     res
);
  import tvds_pkg::*;

  `include "assert_macros.svh"

  logic                  active_r, active_nxt;
  logic                  started_r, started_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [1:0]            req_fluid_r, req_fluid_nxt;
  logic [15:0]           req_volume_r, req_volume_nxt;
  logic                  req_dafter_r, req_dafter_nxt;
  logic [15:0]           level_r, level_nxt;
  logic [3:0]            relays_r, relays_nxt;

  // Open times in Q12 ms of the latched request at the live rates.
  logic [31:0]           src_q, drn_q;

  logic [TIME_WIDTH-1:0] tick_elapsed;
  logic [CMP_W-1:0]      t_q, travel_q, delay_q;
  logic [CMP_W-1:0]      th_dopen, th_src, th_air, th_dclose;
  logic [16:0]           fill_sum;
  logic [15:0]           level_drop;
  logic [3:0]            pin;
  logic [3:0]            rl;
  logic                  done;
  logic [2:0]            status;
  logic                  fin;

  assign src_q = {16'd0, req_volume_r} * {16'd0, rate_of(cfg, req_fluid_r)};
  assign drn_q = {16'd0, req_volume_r} * {16'd0, cfg.drain_ms_per_ml};

  assign tick_elapsed = !started_r ? '0 :
                        (&elapsed_r) ? elapsed_r : elapsed_r + 1'b1;
  assign t_q       = CMP_W'({tick_elapsed, {FRAC_W{1'b0}}});
  assign travel_q  = CMP_W'({cfg.travel_time_ms, {FRAC_W{1'b0}}});
  assign delay_q   = CMP_W'({cfg.drain_delay_ms, {FRAC_W{1'b0}}});
  assign th_dopen  = delay_q + travel_q;
  assign th_src    = CMP_W'(src_q);
  assign th_air    = CMP_W'(src_q) + travel_q;
  assign th_dclose = travel_q + CMP_W'(drn_q) + delay_q;

  assign fill_sum   = {1'b0, level_r} + {1'b0, item.volume};
  assign level_drop = (level_r > req_volume_r) ? level_r - req_volume_r : 16'd0;
  assign pin        = relay_of(req_fluid_r);

  always_comb begin
    active_nxt     = active_r;
    started_nxt    = started_r;
    elapsed_nxt    = elapsed_r;
    req_fluid_nxt  = req_fluid_r;
    req_volume_nxt = req_volume_r;
    req_dafter_nxt = req_dafter_r;
    level_nxt      = level_r;
    relays_nxt     = relays_r;
    status         = ST_TICK;
    fin            = 1'b0;
    rl             = relays_r;
    done           = 1'b0;

    if (fire && item.action) begin
      if (item.fluid_type == FL_NONE) begin
        status = ST_UNDEF;
      end else if (item.fluid_type != FL_DRAIN &&
                   fill_sum > {1'b0, cfg.max_bowl_level}) begin
        status = ST_OVFL;
      end else if (active_r) begin
        status = ST_BUSY;
      end else begin
        status         = ST_ACCEPT;
        req_fluid_nxt  = item.fluid_type;
        req_volume_nxt = item.volume;
        req_dafter_nxt = item.drain_after;
        active_nxt     = 1'b1;
        started_nxt    = 1'b0;
        elapsed_nxt    = '0;
        if (item.fluid_type != FL_DRAIN && !item.drain_after) begin
          level_nxt = fill_sum[15:0];
        end
      end
    end else if (fire && active_r) begin
      started_nxt = 1'b1;
      elapsed_nxt = tick_elapsed;
      if (!started_r) begin
        rl = rl | pin;
      end
      if (req_dafter_r && t_q >= th_dopen) begin
        rl = rl | R_DRAIN;
      end
      // source time up: drain request ends here, fills go to purge
      if (t_q >= th_src) begin
        rl = rl & ~pin;
        if (req_fluid_r == FL_DRAIN) begin
          active_nxt = 1'b0;
          level_nxt  = level_drop;
          fin        = 1'b1;
          done       = 1'b1;
        end else begin
          rl = rl | R_AIR;
        end
      end
      if (!done && t_q >= th_air) begin
        rl = rl & ~R_AIR;
        if (!req_dafter_r) begin
          active_nxt = 1'b0;
          fin        = 1'b1;
          done       = 1'b1;
        end
      end
      if (!done && req_dafter_r && t_q >= th_dclose) begin
        rl         = rl & ~R_DRAIN;
        active_nxt = 1'b0;
        fin        = 1'b1;
      end
      relays_nxt = rl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      started_r    <= 1'b0;
      elapsed_r    <= '0;
      req_fluid_r  <= FL_NONE;
      req_volume_r <= 16'd0;
      req_dafter_r <= 1'b0;
      level_r      <= 16'd0;
      relays_r     <= 4'd0;
    end else begin
      active_r     <= active_nxt;
      started_r    <= started_nxt;
      elapsed_r    <= elapsed_nxt;
      req_fluid_r  <= req_fluid_nxt;
      req_volume_r <= req_volume_nxt;
      req_dafter_r <= req_dafter_nxt;
      level_r      <= level_nxt;
      relays_r     <= relays_nxt;
    end
  end

  always_comb begin
    res.status      = status;
    res.drain_valve = relays_nxt[0];
    res.water_valve = relays_nxt[1];
    res.milk_valve  = relays_nxt[2];
    res.air_valve   = relays_nxt[3];
    res.busy_res    = active_nxt;
    res.finished    = fin;
    res.bowl_level  = level_nxt;
  end

  `TVDS_ASSERT(a_fin_clears_active, clk, rst_n, fire && fin |=> !active_r)
  `TVDS_ASSERT(a_accept_arms, clk, rst_n,
               fire && status == ST_ACCEPT |=> active_r && !started_r)
  `TVDS_ASSERT(a_unstarted_zero, clk, rst_n, active_r && !started_r |-> elapsed_r == '0)

endmodule

`default_nettype wire

// File: sv/timed_valve_dispense_sequencer.sv
// Top level of the timed valve dispense sequencer: beat registers and config.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------
//   in_     | in        | in_valid / in_stall | action, fluid_type, volume, drain_after
//   out_    | out       | out_valid/out_stall | status, four valves, busy_res,
//           |           |                     | finished, bowl_level
//   cfg_    | in        | cfg_we              | cfg_index, cfg_wdata
//
// One beat per cycle sustained while out_stall is low; each beat passes the input
// register, then the result register, through the single step stage.
// rst_n is synchronous: it closes all relays, zeroes the level and loads the
// register defaults. out_stall holds the result register; the input register
// keeps filling until both are full, then in_stall rises.
`default_nettype none

module timed_valve_dispense_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [1:0]                    in_fluid_type,
  input  wire logic [15:0]                   in_volume,
  input  wire logic                          in_drain_after,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_status,
  output logic                               out_drain_valve,
  output logic                               out_water_valve,
  output logic                               out_milk_valve,
  output logic                               out_air_valve,
  output logic                               out_busy_res,
  output logic                               out_finished,
  output logic [15:0]                        out_bowl_level,
  input  wire logic                          cfg_we,
  input  wire logic [tvds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tvds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tvds_pkg::*;

  `include "assert_macros.svh"

  tvds_cfg_t  cfg_r;
  tvds_item_t item_r;
  logic       in_vld_r;
  tvds_res_t  res_r, step_res;
  logic       out_vld_r;
  logic       adv;   // input beat moves through the step into the result reg

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;

  // Register file; the user must see that writes arrive only while no beat is in flight; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drain_ms_per_ml <= RST_RATE;
      cfg_r.water_ms_per_ml <= RST_RATE;
      cfg_r.milk_ms_per_ml  <= RST_RATE;
      cfg_r.max_bowl_level  <= RST_MAX_LEVEL;
      cfg_r.travel_time_ms  <= RST_TRAVEL;
      cfg_r.drain_delay_ms  <= RST_DRAIN_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRAIN_RATE:  cfg_r.drain_ms_per_ml <= cfg_wdata;
        CFG_WATER_RATE:  cfg_r.water_ms_per_ml <= cfg_wdata;
        CFG_MILK_RATE:   cfg_r.milk_ms_per_ml  <= cfg_wdata;
        CFG_MAX_LEVEL:   cfg_r.max_bowl_level  <= cfg_wdata;
        CFG_TRAVEL:      cfg_r.travel_time_ms  <= cfg_wdata;
        CFG_DRAIN_DELAY: cfg_r.drain_delay_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.action      <= in_action;
      item_r.fluid_type  <= in_fluid_type;
      item_r.volume      <= in_volume;
      item_r.drain_after <= in_drain_after;
    end
  end

  tvds_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (step_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= step_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_status      = res_r.status;
  assign out_drain_valve = res_r.drain_valve;
  assign out_water_valve = res_r.water_valve;
  assign out_milk_valve  = res_r.milk_valve;
  assign out_air_valve   = res_r.air_valve;
  assign out_busy_res    = res_r.busy_res;
  assign out_finished    = res_r.finished;
  assign out_bowl_level  = res_r.bowl_level;

  `TVDS_ASSERT(a_fin_not_busy, clk, rst_n, out_vld_r && res_r.finished |-> !res_r.busy_res)
  `TVDS_ASSERT(a_accept_busy, clk, rst_n,
               out_vld_r && res_r.status == ST_ACCEPT |-> res_r.busy_res)
  `TVDS_ASSERT(a_stall_only_full, clk, rst_n, in_stall |-> in_vld_r && out_vld_r)

endmodule

`default_nettype wire
